// ----- sv/assert_macros.svh -----
// Assertion helpers; the enclosing module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/pgr_pkg.sv -----
package pgr_pkg;

   localparam int ROW_BITS   = 7;
   localparam int COL_BITS   = 7;
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int CELLS      = 2 ** ADDR_BITS;
   localparam int VALUE_BITS = 32;
   localparam int ACC_BITS   = VALUE_BITS + 3;
   localparam int CNT_BITS   = 16;
   localparam int H_BITS     = 31;
   localparam int SIZE_BITS  = 8;
   localparam int LABEL_BITS = 8;
   localparam int WORD_BITS  = VALUE_BITS + 1;

   localparam logic [SIZE_BITS-1:0]  MAX_ROWS       = 8'd128;
   localparam logic [SIZE_BITS-1:0]  MAX_COLS       = 8'd128;
   localparam logic [SIZE_BITS-1:0]  MIN_RUN_SIZE   = 8'd3;
   localparam logic [LABEL_BITS-1:0] LABEL_INTERIOR = 8'd2;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_RUN  = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_RUN  = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_HEIGHT = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_SWEEPS = 2'd2,
      REG_HSQ    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CTR,
      ST_UP,
      ST_DN,
      ST_LT,
      ST_RT,
      ST_WR,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] height;
      logic [SIZE_BITS-1:0] width;
      logic [CNT_BITS-1:0]  sweeps;
      logic [H_BITS-1:0]    h_sq;
   } cfg_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } mem_wr_type;

endpackage

// ----- sv/pgr_if.sv -----
interface pgr_req_if import pgr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   logic [ROW_BITS-1:0]    row;
   logic [COL_BITS-1:0]    column;
   logic [LABEL_BITS-1:0]  cell_label;
   logic signed [VALUE_BITS-1:0] initial_value;

   modport source (output valid, command, row, column, cell_label, initial_value,
                   input ready);
   modport sink   (input valid, command, row, column, cell_label, initial_value,
                   output ready);
endinterface

interface pgr_rsp_if import pgr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             result_kind;
   logic signed [VALUE_BITS-1:0] cell_value;

   modport source (output valid, result_kind, cell_value, input ready);
   modport sink   (input valid, result_kind, cell_value, output ready);
endinterface

// ----- sv/poisson_grid_relaxation.sv -----
// Poisson grid relaxation: a 128x128 grid of signed Q16.16 values with an
// interior flag per cell, relaxed in place by Gauss-Seidel sweeps.
// Channels: req_bus takes commands (load, run, read) with a valid/ready
// handshake; rsp_bus returns one transaction per command (command 3 yields
// none); csr_we/csr_index/csr_wdata write grid_height, grid_width, sweep_count
// and h_squared; the user must do so only while the block is idle (unenforced).
// Timing: a load is answered in the cycle after acceptance; a read of a cell in
// the grid passes the memory read register and then the result register; a read
// outside the grid in the cycle after. A new command is taken once the previous
// one is answered, so loads stream at one per cycle while results are taken.
// A run takes about sweep_count * (rows-2) * (cols-2) cell visits: a cell with
// a clear flag passes ST_CTR and ST_UP, an interior cell also ST_DN, ST_LT,
// ST_RT and ST_WR (five reads, a write on the cell memory); ST_DONE ends a run.
// Reset clears the sequencer, the result valid flag and the configuration to
// 128 x 128, zero sweeps and h_squared = 1.0; the cell memory is not cleared and
// must be loaded before use. When the receiver stalls, the result is held in
// the output register and no new command is accepted until it is taken.
module poisson_grid_relaxation import pgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pgr_req_if.sink              req_bus,
   pgr_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [H_BITS-1:0]    csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   // Update configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HEIGHT: cfg_in.height = csr_wdata[SIZE_BITS-1:0];
            REG_WIDTH:  cfg_in.width  = csr_wdata[SIZE_BITS-1:0];
            REG_SWEEPS: cfg_in.sweeps = csr_wdata[CNT_BITS-1:0];
            REG_HSQ:    cfg_in.h_sq   = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height <= MAX_ROWS;
         cfg_ff.width  <= MAX_COLS;
         cfg_ff.sweeps <= '0;
         cfg_ff.h_sq   <= H_BITS'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pgr_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

// ----- sv/pgr_cell_store.sv -----
module pgr_cell_store import pgr_pkg::*; (
   input  logic                 clock,
   input  mem_wr_type           wr,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   // {interior flag, value} per cell
   logic [WORD_BITS-1:0] mem [CELLS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pgr_sequencer.sv -----
`include "assert_macros.svh"

module pgr_sequencer import pgr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   pgr_req_if.sink   req,
   pgr_rsp_if.source rsp
);

   seq_state_type state_ff, state_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [CNT_BITS-1:0] sweep_ff, sweep_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic signed [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;

   mem_wr_type           wr;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic accept, on_grid, run_ok, last_col, last_row, last_sweep, done_cell;
   logic [SIZE_BITS-1:0] rows_used, cols_used;
   logic signed [ACC_BITS-1:0] rd_ext, sum, quarter;
   logic signed [VALUE_BITS-1:0] relaxed;

   pgr_cell_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decode command and grid limits
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign on_grid   = ({1'b0, req.row} < cfg.height) && ({1'b0, req.column} < cfg.width);
   assign rows_used = (cfg.height > MAX_ROWS) ? MAX_ROWS : cfg.height;
   assign cols_used = (cfg.width > MAX_COLS) ? MAX_COLS : cfg.width;
   assign run_ok    = (cfg.height >= MIN_RUN_SIZE) && (cfg.width >= MIN_RUN_SIZE)
                      && (cfg.sweeps != '0);
   assign last_col   = ({1'b0, col_ff} + SIZE_BITS'(2)) >= cols_used;
   assign last_row   = ({1'b0, row_ff} + SIZE_BITS'(2)) >= rows_used;
   assign last_sweep = sweep_ff == (cfg.sweeps - CNT_BITS'(1));
   assign done_cell  = last_col && last_row && last_sweep;

   // Relaxation: floor((sum - h) / 4), saturated
   assign rd_ext  = ACC_BITS'($signed(rd_data[VALUE_BITS-1:0]));
   assign sum     = acc_ff + rd_ext;
   assign quarter = sum >>> 2;
   always_comb begin
      if (quarter[ACC_BITS-1] && !(&quarter[ACC_BITS-2:VALUE_BITS-1])) begin
         relaxed = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else if (!quarter[ACC_BITS-1] && (|quarter[ACC_BITS-2:VALUE_BITS-1])) begin
         relaxed = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else begin
         relaxed = quarter[VALUE_BITS-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.command)
                  CMD_RUN:  state_in = run_ok ? ST_CTR : ST_IDLE;
                  CMD_READ: state_in = on_grid ? ST_READ : ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_CTR:  state_in = ST_UP;
         ST_UP: begin
            if (rd_data[VALUE_BITS]) begin
               state_in = ST_DN;
            end else begin
               state_in = done_cell ? ST_DONE : ST_CTR;
            end
         end
         ST_DN:   state_in = ST_LT;
         ST_LT:   state_in = ST_RT;
         ST_RT:   state_in = ST_WR;
         ST_WR:   state_in = done_cell ? ST_DONE : ST_CTR;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory control and result register
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      wr           = '0;
      rd_addr      = {row_ff, col_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.command)
                  CMD_LOAD: begin
                     wr.en        = on_grid;
                     wr.addr      = {req.row, req.column};
                     wr.data      = {req.cell_label == LABEL_INTERIOR, req.initial_value};
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_LOAD;
                     rsp_value_in = '0;
                  end
                  CMD_RUN: begin
                     row_in   = ROW_BITS'(1);
                     col_in   = COL_BITS'(1);
                     sweep_in = '0;
                     if (!run_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_RUN;
                        rsp_value_in = '0;
                     end
                  end
                  CMD_READ: begin
                     rd_addr = {req.row, req.column};
                     if (!on_grid) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_READ;
                        rsp_value_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_READ;
            rsp_value_in = rd_data[VALUE_BITS-1:0];
         end
         ST_UP: begin
            rd_addr = {row_ff - ROW_BITS'(1), col_ff};
            acc_in  = -ACC_BITS'($signed({1'b0, cfg.h_sq}));
         end
         ST_DN: begin
            rd_addr = {row_ff + ROW_BITS'(1), col_ff};
            acc_in  = sum;
         end
         ST_LT: begin
            rd_addr = {row_ff, col_ff - COL_BITS'(1)};
            acc_in  = sum;
         end
         ST_RT: begin
            rd_addr = {row_ff, col_ff + COL_BITS'(1)};
            acc_in  = sum;
         end
         ST_WR: begin
            wr.en   = 1'b1;
            wr.addr = {row_ff, col_ff};
            wr.data = {1'b1, relaxed};
         end
         ST_DONE: begin
            row_in       = '0;
            col_in       = '0;
            sweep_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_RUN;
            rsp_value_in = '0;
         end
         default: begin
         end
      endcase

      // Advance the raster cursor after a skipped or written cell
      if ((state_ff == ST_WR) || ((state_ff == ST_UP) && !rd_data[VALUE_BITS])) begin
         if (!last_col) begin
            col_in = col_ff + COL_BITS'(1);
         end else begin
            col_in = COL_BITS'(1);
            if (!last_row) begin
               row_in = row_ff + ROW_BITS'(1);
            end else begin
               row_in   = ROW_BITS'(1);
               sweep_in = sweep_ff + CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.cell_value  = rsp_value_ff;

   `ASSERT_NOW(a_wr_only_load_or_update, wr.en, (state_ff == ST_IDLE) || (state_ff == ST_WR))
   `ASSERT_NOW(a_sweep_cursor_interior, (state_ff == ST_CTR) || (state_ff == ST_WR),
      (row_ff != '0) && (col_ff != '0))
   `ASSERT_NEXT(a_read_answers, state_ff == ST_READ,
      rsp_valid_ff && (rsp_kind_ff == KIND_READ))
   `ASSERT_NEXT(a_run_finishes, state_ff == ST_DONE,
      rsp_valid_ff && (rsp_kind_ff == KIND_RUN) && (state_ff == ST_IDLE))

endmodule
